FILE: rtl/shsc_pkg.sv
// ----------------------------------------------------------------------------
// shsc_pkg: shared types and constants for the half/single converter
// Field widths, format constants and the packed result item type.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package shsc_pkg;

	// Number of lane fields carried by one item, and how many of them convert.
	localparam int NUM_FIELDS = 4;
	localparam int LANES      = 4;

	localparam int WORD_W = 32;
	localparam int DEST_W = 5;

	typedef logic [WORD_W-1:0] word_t;
	typedef logic [DEST_W-1:0] dest_t;

	typedef enum logic {
		OP_WIDEN  = 1'b0,
		OP_NARROW = 1'b1
	} op_t;

	// Binary32 constants.
	localparam logic [31:0] SGL_INF     = 32'h7F80_0000;
	localparam logic [31:0] SGL_QUIET   = 32'h0040_0000;
	localparam logic [7:0]  SGL_EXP_MAX = 8'hFF;

	// Binary16 constants.
	localparam logic [4:0]  HLF_EXP_MAX = 5'h1F;
	localparam logic [14:0] HLF_INF     = 15'h7C00;
	localparam logic [14:0] HLF_QNAN    = 15'h7E00;

	// Difference of the exponent biases (127 - 15).
	localparam logic [7:0]  BIAS_DIFF   = 8'd112;

	// One result item after the lanes are merged.
	typedef struct packed {
		word_t [NUM_FIELDS-1:0] lane;
		dest_t                  dest;
		logic                   pair;
	} shsc_result_t;

endpackage

FILE: rtl/shsc_in_if.sv
// ----------------------------------------------------------------------------
// shsc_in_if: input channel of the half/single converter
// Valid/ready channel carrying the direction, four source lanes and the
// destination register index.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface shsc_in_if import shsc_pkg::*; ();

	logic  valid;
	logic  ready;
	logic  op;
	word_t lane0_in;
	word_t lane1_in;
	word_t lane2_in;
	word_t lane3_in;
	dest_t dest_reg;

	modport source (
		output valid, op, lane0_in, lane1_in, lane2_in, lane3_in, dest_reg,
		input  ready
	);

	modport sink (
		input  valid, op, lane0_in, lane1_in, lane2_in, lane3_in, dest_reg,
		output ready
	);

endinterface

FILE: rtl/shsc_out_if.sv
// ----------------------------------------------------------------------------
// shsc_out_if: output channel of the half/single converter
// Valid/ready channel carrying four converted lanes, the destination index
// and the register pair flag.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface shsc_out_if import shsc_pkg::*; ();

	logic  valid;
	logic  ready;
	word_t lane0_out;
	word_t lane1_out;
	word_t lane2_out;
	word_t lane3_out;
	dest_t dest_index;
	logic  writes_pair;

	modport source (
		output valid, lane0_out, lane1_out, lane2_out, lane3_out, dest_index,
		output writes_pair,
		input  ready
	);

	modport sink (
		input  valid, lane0_out, lane1_out, lane2_out, lane3_out, dest_index,
		input  writes_pair,
		output ready
	);

endinterface

FILE: rtl/shsc_lane.sv
// ----------------------------------------------------------------------------
// shsc_lane: one conversion lane
// Combinational binary16 to binary32 widening or binary32 to binary16
// narrowing with flush to zero and round to nearest even.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module shsc_lane import shsc_pkg::*; (
	input  logic  op,
	input  word_t src,
	output word_t res
);

	word_t widen_res;
	logic [15:0] narrow_res;

	// Widening path.
	logic       h_sign;
	logic [4:0] h_exp;
	logic [9:0] h_man;
	logic [7:0] w_exp;

	assign h_sign = src[15];
	assign h_exp  = src[14:10];
	assign h_man  = src[9:0];
	assign w_exp  = {3'b000, h_exp} + BIAS_DIFF;

	always_comb begin
		if (h_exp == 5'd0) begin
			widen_res = {h_sign, 31'd0};
		end else if (h_exp == HLF_EXP_MAX) begin
			if (h_man == 10'd0) begin
				widen_res = {h_sign, 31'd0} | SGL_INF;
			end else begin
				widen_res = {h_sign, 31'd0} | SGL_INF | SGL_QUIET
					| {10'd0, h_man[8:0], 13'd0};
			end
		end else begin
			widen_res = {h_sign, w_exp, h_man, 13'd0};
		end
	end

	// Narrowing path.
	logic        f_sign;
	logic [7:0]  f_exp;
	logic [22:0] f_man;
	logic [7:0]  hex;
	logic [9:0]  kept;
	logic        rnd_up;
	logic [10:0] kept_r;
	logic [7:0]  hex_r;

	assign f_sign = src[31];
	assign f_exp  = src[30:23];
	assign f_man  = src[22:0];
	assign hex    = f_exp - BIAS_DIFF;
	assign kept   = f_man[22:13];
	assign rnd_up = f_man[12] & ((|f_man[11:0]) | kept[0]);
	assign kept_r = {1'b0, kept} + {10'd0, rnd_up};
	assign hex_r  = hex + {7'd0, kept_r[10]};

	always_comb begin
		if (f_exp == SGL_EXP_MAX) begin
			if (f_man == 23'd0) begin
				narrow_res = {f_sign, HLF_INF};
			end else begin
				narrow_res = {f_sign, HLF_QNAN | {6'd0, f_man[21:13]}};
			end
		end else if (f_exp <= BIAS_DIFF) begin
			// Zero, denormal, or below the smallest half normal.
			narrow_res = {f_sign, 15'd0};
		end else if (hex_r >= {3'b000, HLF_EXP_MAX}) begin
			// Overflow, before or after the rounding carry.
			narrow_res = {f_sign, HLF_INF};
		end else begin
			narrow_res = {f_sign, hex_r[4:0], kept_r[9:0]};
		end
	end

	assign res = (op == OP_NARROW) ? {16'd0, narrow_res} : widen_res;

endmodule

FILE: rtl/shsc_merge.sv
// ----------------------------------------------------------------------------
// shsc_merge: lane merge and output stage
// Packs the lane results with the destination fields and holds them in an
// output register backed by a skid register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module shsc_merge import shsc_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_ready,
	input  logic                   op,
	input  dest_t                  dest,
	input  word_t [NUM_FIELDS-1:0] lane_res,
	shsc_out_if.source             out_ch
);

	shsc_result_t merged;
	shsc_result_t out_data_q;
	shsc_result_t skid_data_q;
	logic         out_valid_q;
	logic         skid_valid_q;
	logic         out_free;

	always_comb begin
		merged.lane = lane_res;
		merged.dest = dest;
		merged.pair = (op == OP_WIDEN);
	end

	assign in_ready = ~skid_valid_q;
	assign out_free = out_ch.ready | ~out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (out_free) begin
			if (skid_valid_q) begin
				out_valid_q  <= 1'b1;
				skid_valid_q <= 1'b0;
			end else begin
				out_valid_q <= in_valid;
			end
		end else if (in_valid && in_ready) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free) begin
			if (skid_valid_q) begin
				out_data_q <= skid_data_q;
			end else begin
				out_data_q <= merged;
			end
		end else if (in_valid && in_ready) begin
			skid_data_q <= merged;
		end
	end

	assign out_ch.valid       = out_valid_q;
	assign out_ch.lane0_out   = out_data_q.lane[0];
	assign out_ch.lane1_out   = out_data_q.lane[1];
	assign out_ch.lane2_out   = out_data_q.lane[2];
	assign out_ch.lane3_out   = out_data_q.lane[3];
	assign out_ch.dest_index  = out_data_q.dest;
	assign out_ch.writes_pair = out_data_q.pair;

endmodule

FILE: rtl/simd_half_single_convert.sv
// ----------------------------------------------------------------------------
// simd_half_single_convert: four-lane binary16/binary32 converter
// An accepted item enters the output register, or the one-item skid register
// under stall. Throughput: one item per cycle while the skid is empty; the
// lanes are combinational ahead of a single output register.
// Reset: arst_n clears the output and skid valid flags; data is not reset.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module simd_half_single_convert import shsc_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	shsc_in_if.sink    in_ch,
	shsc_out_if.source out_ch
);

	// The source lanes are gathered into an array so that the lane copies
	// can be generated. Fields beyond the configured lane count give zero.
	word_t [NUM_FIELDS-1:0] lane_src;
	word_t [NUM_FIELDS-1:0] lane_res;
	logic                   merge_ready;

	assign lane_src[0] = in_ch.lane0_in;
	assign lane_src[1] = in_ch.lane1_in;
	assign lane_src[2] = in_ch.lane2_in;
	assign lane_src[3] = in_ch.lane3_in;

	// One converter per active lane. Each lane looks only at its own source
	// element and the per-item direction, so all lanes run side by side.
	for (genvar k = 0; k < NUM_FIELDS; k++) begin : g_lane
		if (k < LANES) begin : g_active
			shsc_lane u_lane (
				.op  (in_ch.op),
				.src (lane_src[k]),
				.res (lane_res[k])
			);
		end else begin : g_idle
			assign lane_res[k] = '0;
		end
	end

	// The merge stage joins the lane results with the destination index and
	// the pair flag, and decouples the two handshakes. The input side stays
	// ready while a finished item waits, until the skid register is full.
	shsc_merge u_merge (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_ch.valid),
		.in_ready (merge_ready),
		.op       (in_ch.op),
		.dest     (in_ch.dest_reg),
		.lane_res (lane_res),
		.out_ch   (out_ch)
	);

	assign in_ch.ready = merge_ready;

endmodule

FILE: tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the four-lane half/single converter
// Drives directed and random vector conversions in both directions through
// the input channel, with random gaps on the sender and random stalls on the
// receiver. A scoreboard predicts every lane from the IEEE formats and
// compares each result item, field by field, against the oldest prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;

	import shsc_pkg::*;

	// Cycles without any handshake on either channel before the run is declared hung.
	localparam int HANG_LIMIT   = 2000;
	// Extra cycles after the last result so that nothing stray slips out unseen.
	localparam int TAIL_CYCLES  = 12;
	localparam int DIRECT_COUNT = 16;
	localparam int RANDOM_COUNT = 850;

	// ------------------------------------------------------------------------
	// Scoreboard: predicts each conversion and holds the results still owed.
	// ------------------------------------------------------------------------
	class convert_scoreboard;
		shsc_result_t owed[$];
		int           mismatches;
		int           widen_items;
		int           narrow_items;
		int           results_checked;

		function new();
			mismatches      = 0;
			widen_items     = 0;
			narrow_items    = 0;
			results_checked = 0;
		endfunction

		// Half to single. Denormals flush to signed zero, and NaNs come out quiet
		// with the low nine mantissa bits carried up into the single mantissa.
		function word_t half_to_single(logic [15:0] h);
			logic [4:0] ex;
			logic [9:0] man;
			logic [7:0] sexp;
			ex  = h[14:10];
			man = h[9:0];
			if (ex == 5'd0) begin
				return {h[15], 31'd0};
			end
			if (ex == HLF_EXP_MAX) begin
				if (man == 10'd0) begin
					return {h[15], SGL_EXP_MAX, 23'd0};
				end
				return {h[15], SGL_EXP_MAX, 1'b1, man[8:0], 13'd0};
			end
			sexp = {3'd0, ex} + BIAS_DIFF;
			return {h[15], sexp, man, 13'd0};
		endfunction

		// Single to half. The underflow test is made on the exponent before any
		// rounding, so a value just below the smallest half normal stays zero.
		function word_t single_to_half(word_t f);
			logic        sgn;
			logic [7:0]  ex;
			logic [22:0] man;
			logic [7:0]  hexp;
			logic [10:0] kept;
			logic        half_rbit;
			logic        sticky;
			sgn = f[31];
			ex  = f[30:23];
			man = f[22:0];
			if (ex == SGL_EXP_MAX) begin
				if (man == 23'd0) begin
					return {16'd0, sgn, HLF_INF};
				end
				return {16'd0, sgn, HLF_QNAN | {6'd0, man[21:13]}};
			end
			if (ex <= BIAS_DIFF) begin
				return {16'd0, sgn, 15'd0};
			end
			hexp = ex - BIAS_DIFF;
			if (hexp >= {3'd0, HLF_EXP_MAX}) begin
				return {16'd0, sgn, HLF_INF};
			end
			kept      = {1'b0, man[22:13]};
			half_rbit = man[12];
			sticky    = (man[11:0] != 12'd0);
			if (half_rbit && (sticky || kept[0])) begin
				kept = kept + 11'd1;
				if (kept == 11'h400) begin
					kept = 11'd0;
					hexp = hexp + 8'd1;
					if (hexp >= {3'd0, HLF_EXP_MAX}) begin
						return {16'd0, sgn, HLF_INF};
					end
				end
			end
			return {16'd0, sgn, hexp[4:0], kept[9:0]};
		endfunction

		function void note_input(op_t op, word_t l0, word_t l1, word_t l2, word_t l3,
				dest_t dest);
			shsc_result_t exp_item;
			word_t        src [NUM_FIELDS];
			src[0] = l0;
			src[1] = l1;
			src[2] = l2;
			src[3] = l3;
			for (int k = 0; k < NUM_FIELDS; k++) begin
				if (k >= LANES) begin
					exp_item.lane[k] = '0;
				end else if (op == OP_NARROW) begin
					exp_item.lane[k] = single_to_half(src[k]);
				end else begin
					exp_item.lane[k] = half_to_single(src[k][15:0]);
				end
			end
			exp_item.dest = dest;
			exp_item.pair = (op == OP_WIDEN);
			if (op == OP_NARROW) begin
				narrow_items++;
			end else begin
				widen_items++;
			end
			owed.push_back(exp_item);
		endfunction

		function void check_result(shsc_result_t got);
			shsc_result_t exp_item;
			if (owed.size() == 0) begin
				$display("%0t: result item arrived with nothing outstanding", $time);
				mismatches++;
				return;
			end
			exp_item = owed.pop_front();
			results_checked++;
			for (int k = 0; k < NUM_FIELDS; k++) begin
				if (got.lane[k] !== exp_item.lane[k]) begin
					$display("%0t: lane%0d_out expected %08h actual %08h", $time, k,
						exp_item.lane[k], got.lane[k]);
					mismatches++;
				end
			end
			if (got.dest !== exp_item.dest) begin
				$display("%0t: dest_index expected %0d actual %0d", $time,
					exp_item.dest, got.dest);
				mismatches++;
			end
			if (got.pair !== exp_item.pair) begin
				$display("%0t: writes_pair expected %0b actual %0b", $time,
					exp_item.pair, got.pair);
				mismatches++;
			end
		endfunction
	endclass

	// ------------------------------------------------------------------------
	// Clock, channels and the block under test.
	// ------------------------------------------------------------------------
	logic clk;
	logic arst_n;

	shsc_in_if  in_ch ();
	shsc_out_if out_ch ();

	simd_half_single_convert u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_ch),
		.out_ch (out_ch)
	);

	initial begin
		clk = 1'b0;
	end

	always #4 clk = ~clk;

	convert_scoreboard sb;
	int                idle_cycles;

	// Gap length used by both sides: mostly none, sometimes short, and
	// now and then a long pause.
	function automatic int pick_gap();
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < 60) begin
			return 0;
		end
		if (roll < 90) begin
			return $urandom_range(1, 3);
		end
		return $urandom_range(4, 25);
	endfunction

	// Random half in the low 16 bits. The upper half is noise that the block
	// must ignore in widen mode.
	function automatic word_t rand_half_lane();
		logic [4:0] ex;
		logic [9:0] man;
		man = 10'($urandom);
		case ($urandom_range(0, 5))
			0: ex = 5'd0;
			1: ex = HLF_EXP_MAX;
			2: ex = 5'($urandom);
			default: ex = 5'($urandom_range(1, 30));
		endcase
		if ($urandom_range(0, 7) == 0) begin
			man = 10'd0;
		end
		return {16'($urandom), 1'($urandom), ex, man};
	endfunction

	// Random single, weighted toward the half normal range and the edges of it,
	// with mantissa tails that land on the rounding ties and carries.
	function automatic word_t rand_single_lane();
		logic [7:0]  ex;
		logic [22:0] man;
		man = 23'($urandom);
		case ($urandom_range(0, 9))
			0: return $urandom;
			1: ex = 8'd0;
			2: ex = SGL_EXP_MAX;
			3: ex = 8'($urandom_range(1, 112));
			4: ex = 8'($urandom_range(143, 254));
			5: begin
				case ($urandom_range(0, 3))
					0: ex = 8'd112;
					1: ex = 8'd113;
					2: ex = 8'd142;
					default: ex = 8'd143;
				endcase
			end
			default: ex = 8'($urandom_range(113, 142));
		endcase
		case ($urandom_range(0, 5))
			0: man[12:0] = 13'h1000;
			1: man[12:0] = 13'h0FFF;
			2: man[22:12] = '1;
			3: man = 23'd0;
			default: ;
		endcase
		return {1'($urandom), ex, man};
	endfunction

	// ------------------------------------------------------------------------
	// Sender. Entered and left at a falling edge; valid stays high from one
	// item to the next unless a gap is taken, so it is never lowered and
	// raised in the same step.
	// ------------------------------------------------------------------------
	task automatic send_item(op_t op, word_t l0, word_t l1, word_t l2, word_t l3,
			dest_t dest, int gap);
		in_ch.valid    = 1'b1;
		in_ch.op       = op;
		in_ch.lane0_in = l0;
		in_ch.lane1_in = l1;
		in_ch.lane2_in = l2;
		in_ch.lane3_in = l3;
		in_ch.dest_reg = dest;
		do begin
			@(posedge clk);
		end while (!in_ch.ready);
		@(negedge clk);
		if (gap > 0) begin
			in_ch.valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
	endtask

	// Directed items: every class of value in both directions, four lanes at a
	// time, with both extremes of the destination index.
	task automatic run_directed();
		// Widen: zeros and denormals flush to signed zero.
		send_item(OP_WIDEN, 32'h0000_0000, 32'h0000_8000, 32'h0000_0001, 32'h0000_83FF,
			5'd0, 0);
		// Widen: infinities, and NaNs with and without the top mantissa bit.
		send_item(OP_WIDEN, 32'h0000_7C00, 32'h0000_FC00, 32'h0000_7C01, 32'hFFFF_7FFF,
			5'd31, 0);
		// Widen: normals at both ends of the range, upper bits set as noise.
		send_item(OP_WIDEN, 32'hFFFF_3C00, 32'hA5A5_0400, 32'h5A5A_7BFF, 32'hFFFF_FBFF,
			5'd17, 1);
		send_item(OP_WIDEN, 32'h1234_7D55, 32'hFFFF_FE00, 32'h0000_C000, 32'hFFFF_0000,
			5'd1, 0);
		// Narrow: zeros and denormals.
		send_item(OP_NARROW, 32'h0000_0000, 32'h8000_0000, 32'h007F_FFFF, 32'h8000_0001,
			5'd0, 0);
		// Narrow: infinities and NaNs, the last one with every bit set.
		send_item(OP_NARROW, 32'h7F80_0000, 32'hFF80_0000, 32'h7F80_0001, 32'hFFFF_FFFF,
			5'd31, 2);
		// Narrow: underflow decided before rounding, and the smallest half normal.
		send_item(OP_NARROW, 32'h387F_FFFF, 32'h3880_0000, 32'h0080_0000, 32'hB87F_FFFF,
			5'd9, 0);
		// Narrow: overflow, the largest half, a round-up carry into infinity, and
		// a value just short of rounding.
		send_item(OP_NARROW, 32'h4780_0000, 32'h477F_E000, 32'h477F_F000, 32'hC77F_EFFF,
			5'd22, 0);
		// Narrow: ties to even in both directions, and just off the tie.
		send_item(OP_NARROW, 32'h3F80_1000, 32'h3F80_3000, 32'h3F80_1001, 32'hBF80_0FFF,
			5'd5, 0);
		// Narrow: rounding carry bumps the exponent without overflow.
		send_item(OP_NARROW, 32'h3FFF_F000, 32'hBFFF_FFFF, 32'h387F_E000, 32'h3880_0FFF,
			5'd30, 3);
		// Narrow: exponents far beyond the half range, and NaN payloads.
		send_item(OP_NARROW, 32'h4F00_0000, 32'hFF00_0000, 32'h7FC0_0000, 32'hFFBF_E000,
			5'd16, 0);
		send_item(OP_NARROW, 32'h7F7F_FFFF, 32'h0000_0001, 32'h4700_0000, 32'h3380_0000,
			5'd15, 0);
		// Alternate direction on back-to-back items.
		send_item(OP_WIDEN, 32'h0000_3555, 32'h0000_83FF, 32'h0000_7BFF, 32'h0000_0400,
			5'd31, 0);
		send_item(OP_NARROW, 32'h3EAA_AAAB, 32'h3DCC_CCCD, 32'h4049_0FDB, 32'hC2F6_E979,
			5'd0, 0);
		send_item(OP_WIDEN, 32'h8000_FFFF, 32'h7FFF_8001, 32'h0000_4248, 32'hFFFF_B0E6,
			5'd10, 0);
		send_item(OP_NARROW, 32'h0000_0000, 32'h7F80_0000, 32'h477F_F000, 32'h3F80_1000,
			5'd21, 4);
	endtask

	// Random items. Every so often a burst of items goes out without gaps.
	task automatic run_random();
		op_t op;
		int  gap;
		for (int n = 0; n < RANDOM_COUNT; n++) begin
			op  = op_t'($urandom_range(0, 1));
			gap = ((n % 150) < 30) ? 0 : pick_gap();
			if (op == OP_NARROW) begin
				send_item(op, rand_single_lane(), rand_single_lane(), rand_single_lane(),
					rand_single_lane(), dest_t'($urandom), gap);
			end else begin
				send_item(op, rand_half_lane(), rand_half_lane(), rand_half_lane(),
					rand_half_lane(), dest_t'($urandom), gap);
			end
		end
	endtask

	// ------------------------------------------------------------------------
	// Receiver. Ready changes on the falling edge: random stalls, with whole
	// stretches where it is held high throughout.
	// ------------------------------------------------------------------------
	int stall_left;
	int phase_left;
	bit steady_phase;

	initial begin
		stall_left   = 0;
		phase_left   = 0;
		steady_phase = 1'b0;
	end

	always @(negedge clk) begin
		if (phase_left == 0) begin
			steady_phase = ($urandom_range(0, 3) == 0);
			phase_left   = $urandom_range(50, 300);
		end else begin
			phase_left--;
		end
		if (stall_left > 0) begin
			out_ch.ready = 1'b0;
			stall_left--;
		end else begin
			out_ch.ready = 1'b1;
			if (!steady_phase) begin
				stall_left = pick_gap();
			end
		end
	end

	// ------------------------------------------------------------------------
	// Monitor. Both channels are sampled at the rising edge, where the bench's
	// own inputs, driven at the falling edge, are stable.
	// ------------------------------------------------------------------------
	always @(posedge clk) begin
		shsc_result_t got;
		if (arst_n) begin
			if (in_ch.valid && in_ch.ready) begin
				sb.note_input(op_t'(in_ch.op), in_ch.lane0_in, in_ch.lane1_in,
					in_ch.lane2_in, in_ch.lane3_in, in_ch.dest_reg);
			end
			if (out_ch.valid && out_ch.ready) begin
				got.lane[0] = out_ch.lane0_out;
				got.lane[1] = out_ch.lane1_out;
				got.lane[2] = out_ch.lane2_out;
				got.lane[3] = out_ch.lane3_out;
				got.dest    = out_ch.dest_index;
				got.pair    = out_ch.writes_pair;
				sb.check_result(got);
			end
		end
	end

	// Watchdog: any stretch this long without a handshake means the block hung.
	always @(posedge clk) begin
		if (!arst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= HANG_LIMIT) begin
			$display("%0t: no handshake for %0d cycles", $time, HANG_LIMIT);
			$display("simulation failed");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	// ------------------------------------------------------------------------
	// Main sequence: reset once, directed items, random items, then drain.
	// ------------------------------------------------------------------------
	initial begin
		sb             = new();
		idle_cycles    = 0;
		arst_n         = 1'b0;
		in_ch.valid    = 1'b0;
		in_ch.op       = OP_WIDEN;
		in_ch.lane0_in = '0;
		in_ch.lane1_in = '0;
		in_ch.lane2_in = '0;
		in_ch.lane3_in = '0;
		in_ch.dest_reg = '0;
		out_ch.ready   = 1'b0;

		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		run_directed();
		run_random();
		in_ch.valid = 1'b0;

		// Wait for every owed result, then a short tail to catch anything extra.
		while (sb.owed.size() != 0) begin
			@(posedge clk);
		end
		repeat (TAIL_CYCLES) @(posedge clk);

		$display("Converted %0d widen and %0d narrow items through four lanes,",
			sb.widen_items, sb.narrow_items);
		$display("with random gaps and stalls; %0d results checked, %0d mismatches.",
			sb.results_checked, sb.mismatches);
		if (sb.mismatches == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

endmodule

FILE: sim.f
rtl/shsc_pkg.sv
rtl/shsc_in_if.sv
rtl/shsc_out_if.sv
rtl/shsc_lane.sv
rtl/shsc_merge.sv
rtl/simd_half_single_convert.sv
tb/tb_top.sv
